// ===== design/rdsc_pkg.sv =====
// Shared types, constants and helper functions of the radix digit string converter.
package rdsc_pkg;

  localparam int VALUE_W = 64;
  localparam int RADIX_W = 5;
  localparam int REM_W   = 4;
  localparam int CHAR_W  = 7;

  // The divider retires this many quotient bits in each cycle.
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = VALUE_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = CHAR_W'(97);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SETTLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } div_status_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] c;
    if (r < RADIX_MIN) begin
      c = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      c = RADIX_MAX;
    end else begin
      c = r;
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] glyph(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < REM_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LOWER_A + CHAR_W'(d - REM_W'(10));
    end
    return c;
  endfunction

endpackage

// ===== design/rdsc_channels.sv =====
// Valid/ready channel interfaces for the operand and the digit stream.
interface rdsc_operand_if;
  logic                              valid;
  logic                              ready;
  logic [rdsc_pkg::VALUE_W-1:0]      value;
  logic [rdsc_pkg::RADIX_W-1:0]      radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rdsc_digit_if;
  logic                              valid;
  logic                              ready;
  logic [rdsc_pkg::CHAR_W-1:0]       digit_char;
  logic                              last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ===== design/rdsc_divider.sv =====
// Iterative divider: splits a 64-bit value by a small radix, eight quotient bits a cycle.
module rdsc_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rdsc_pkg::VALUE_W-1:0]   dividend,
  input  logic [rdsc_pkg::RADIX_W-1:0]   divisor,
  output logic [rdsc_pkg::VALUE_W-1:0]   quot,
  output rdsc_pkg::div_status_t          status
);

  logic [rdsc_pkg::VALUE_W-1:0]   work;
  logic [rdsc_pkg::VALUE_W-1:0]   work_next;
  logic [rdsc_pkg::REM_W-1:0]     rem;
  logic [rdsc_pkg::REM_W-1:0]     rem_next;
  logic [rdsc_pkg::RADIX_W-1:0]   div_r;
  logic [rdsc_pkg::DIV_CNT_W-1:0] cnt;
  logic                           running;
  logic                           done;
  logic                           last_step;

  // Restoring division on the top bits of the working word; quotient bits
  // shift in at the bottom, so after all steps the word holds the quotient.
  always_comb begin
    logic [rdsc_pkg::RADIX_W-1:0] p;
    logic [rdsc_pkg::REM_W-1:0]   r;
    logic [rdsc_pkg::VALUE_W-1:0] w;
    r = rem;
    w = work;
    for (int i = 0; i < rdsc_pkg::DIV_BITS; i++) begin
      p = {r, w[rdsc_pkg::VALUE_W-1]};
      w = {w[rdsc_pkg::VALUE_W-2:0], 1'b0};
      if (p >= div_r) begin
        r    = rdsc_pkg::REM_W'(p - div_r);
        w[0] = 1'b1;
      end else begin
        r = p[rdsc_pkg::REM_W-1:0];
      end
    end
    rem_next  = r;
    work_next = w;
  end

  assign last_step = running && (cnt == rdsc_pkg::DIV_CNT_W'(rdsc_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= last_step;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + rdsc_pkg::DIV_CNT_W'(1);
        if (last_step) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= dividend;
      rem   <= '0;
      div_r <= divisor;
    end else if (running) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quot        = work;
  assign status.done = done;
  assign status.rem  = rem;

endmodule

// ===== design/rdsc_digit_mem.sv =====
// Digit store: one write port, one registered read port.
module rdsc_digit_mem #(
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [rdsc_pkg::REM_W-1:0]   wr_data,
  input  logic [AW-1:0]                rd_addr,
  output logic [rdsc_pkg::REM_W-1:0]   rd_data
);

  logic [rdsc_pkg::REM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/radix_digit_string_converter_unit.sv =====
// Radix digit string converter: an unsigned 64-bit value in, its ASCII digit string out.
//
// Each item on the operand channel carries a 64-bit unsigned value and a
// radix; a radix below 2 is used as 2 and one above 16 as 16. The block
// answers with one item per digit character on the digit channel, most
// significant digit first, in lower case ('0'-'9', then 'a'-'f'), and the
// final, least significant character has last set. A value of zero gives the
// single character '0'. At most MAX_DIGITS digits are kept; if a value needs
// more, only its MAX_DIGITS least significant digits are sent. The operand
// channel is ready only while the block is idle, that is from the cycle after
// the final character has been placed in the output register until the next
// item is accepted. One shared divider produces each digit, retiring eight
// quotient bits a cycle; for each digit it divides, then the remainder is
// stored and the divider restarts. A value is first divided digit by
// digit, then its first digit is read from the store and loaded into the
// output register, and then its characters are sent. No item is accepted
// while a conversion is under way. The digit store needs no clearing after
// reset.
module radix_digit_string_converter_unit #(
  parameter int MAX_DIGITS = 64
) (
  input  logic             clk,
  input  logic             rst,
  rdsc_operand_if.sink     operand,
  rdsc_digit_if.source     digit
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);

  rdsc_pkg::state_t state;
  rdsc_pkg::state_t state_next;

  logic [CW-1:0]                  digit_count;
  logic [CW-1:0]                  digit_count_next;
  logic [CW-1:0]                  count_dec;
  logic [rdsc_pkg::RADIX_W-1:0]   radix;
  logic [rdsc_pkg::RADIX_W-1:0]   radix_in;

  logic                           accept;
  logic                           value_zero;
  logic                           stop;
  logic                           load_out;

  logic                           div_start;
  logic [rdsc_pkg::VALUE_W-1:0]   div_dividend;
  logic [rdsc_pkg::RADIX_W-1:0]   div_divisor;
  logic [rdsc_pkg::VALUE_W-1:0]   div_quot;
  rdsc_pkg::div_status_t          div_status;

  logic                           wr_en;
  logic [rdsc_pkg::REM_W-1:0]     wr_data;
  logic [AW-1:0]                  rd_addr;
  logic [rdsc_pkg::REM_W-1:0]     rd_data;

  logic                           out_valid;
  logic [rdsc_pkg::CHAR_W-1:0]    out_char;
  logic                           out_last;

  assign accept     = operand.valid && operand.ready;
  assign value_zero = (operand.value == '0);
  assign radix_in   = rdsc_pkg::clamp_radix(operand.radix);

  // Division ends once the quotient reaches zero or the store is full.
  assign stop = (div_quot == '0) || (digit_count == CW'(MAX_DIGITS - 1));

  // While emitting, the output register takes a new character whenever it is empty or
  // its current character leaves in this cycle.
  assign load_out = (state == rdsc_pkg::ST_EMIT) && (!out_valid || digit.ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rdsc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = value_zero ? rdsc_pkg::ST_SETTLE : rdsc_pkg::ST_DIVIDE;
        end
      end
      rdsc_pkg::ST_DIVIDE: begin
        if (div_status.done && stop) begin
          state_next = rdsc_pkg::ST_SETTLE;
        end
      end
      rdsc_pkg::ST_SETTLE: begin
        state_next = rdsc_pkg::ST_EMIT;
      end
      rdsc_pkg::ST_EMIT: begin
        if (load_out && (digit_count == CW'(1))) begin
          state_next = rdsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rdsc_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: operand ready, divider control, store writes and the digit count.
  always_comb begin
    operand.ready    = 1'b0;
    div_start        = 1'b0;
    div_dividend     = div_quot;
    div_divisor      = radix;
    wr_en            = 1'b0;
    wr_data          = div_status.rem;
    digit_count_next = digit_count;
    case (state)
      rdsc_pkg::ST_IDLE: begin
        operand.ready = 1'b1;
        div_dividend  = operand.value;
        div_divisor   = radix_in;
        wr_data       = '0;
        if (accept) begin
          div_start        = !value_zero;
          wr_en            = value_zero;
          digit_count_next = value_zero ? CW'(1) : '0;
        end
      end
      rdsc_pkg::ST_DIVIDE: begin
        if (div_status.done) begin
          wr_en            = 1'b1;
          div_start        = !stop;
          digit_count_next = digit_count + CW'(1);
        end
      end
      rdsc_pkg::ST_SETTLE: begin
        digit_count_next = digit_count;
      end
      rdsc_pkg::ST_EMIT: begin
        if (load_out) begin
          digit_count_next = digit_count - CW'(1);
        end
      end
      default: begin
        digit_count_next = '0;
      end
    endcase
  end

  // The store is read one step ahead, so the digit for the current count is
  // waiting in the read register when the output register can take it.
  assign count_dec = digit_count_next - CW'(1);
  assign rd_addr   = count_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rdsc_pkg::ST_IDLE;
      digit_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      digit_count <= digit_count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (digit.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      radix <= radix_in;
    end
    if (load_out) begin
      out_char <= rdsc_pkg::glyph(rd_data);
      out_last <= (digit_count == CW'(1));
    end
  end

  rdsc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .status   (div_status)
  );

  rdsc_digit_mem #(
    .DEPTH (MAX_DIGITS)
  ) u_digit_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (digit_count[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign digit.valid      = out_valid;
  assign digit.digit_char = out_char;
  assign digit.last       = out_last;

endmodule

// ===== test/radix_digit_string_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the radix digit string converter unit.
module radix_digit_string_converter_unit_tb;

  localparam int DIGIT_CAP      = 64;
  localparam int RANDOM_ITEMS   = 305;
  localparam int STALL_LIMIT    = 20000;
  localparam int REPORT_LIMIT   = 10;
  // The receiver holds off once for a long stretch (HOLD_CYCLES) after HOLD_AFTER characters.
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 300;

  typedef struct {
    logic [rdsc_pkg::VALUE_W-1:0] value;
    logic [rdsc_pkg::RADIX_W-1:0] radix;
    bit                           drain_first;
  } operand_t;

  typedef struct {
    logic [rdsc_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } char_t;

  logic clk;
  logic rst;

  rdsc_operand_if operand_ch ();
  rdsc_digit_if   digit_ch ();

  radix_digit_string_converter_unit #(
    .MAX_DIGITS(DIGIT_CAP)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .operand(operand_ch),
    .digit  (digit_ch)
  );

  operand_t operand_backlog[$];
  char_t    pending_chars[$];
  int       mismatches;
  int       chars_seen;
  int       operands_offered;
  int       quiet_cycles;
  int       hold_left;
  bit       hold_done;

  // Spells one value in its clamped radix and queues the characters it should
  // produce, most significant first, with the end mark on the final one.
  function automatic void spell_value(input logic [rdsc_pkg::VALUE_W-1:0] value,
                                      input logic [rdsc_pkg::RADIX_W-1:0] radix);
    logic [rdsc_pkg::VALUE_W-1:0] base;
    logic [rdsc_pkg::VALUE_W-1:0] rest;
    logic [rdsc_pkg::REM_W-1:0]   rems[DIGIT_CAP];
    int                           count;
    char_t                        c;
    base = rdsc_pkg::VALUE_W'(radix);
    if (base < rdsc_pkg::VALUE_W'(rdsc_pkg::RADIX_MIN)) begin
      base = rdsc_pkg::VALUE_W'(rdsc_pkg::RADIX_MIN);
    end
    if (base > rdsc_pkg::VALUE_W'(rdsc_pkg::RADIX_MAX)) begin
      base = rdsc_pkg::VALUE_W'(rdsc_pkg::RADIX_MAX);
    end
    rest  = value;
    count = 0;
    if (rest == '0) begin
      rems[0] = '0;
      count   = 1;
    end
    while (rest != '0 && count < DIGIT_CAP) begin
      rems[count] = rdsc_pkg::REM_W'(rest % base);
      rest        = rest / base;
      count++;
    end
    for (int k = count; k > 0; k--) begin
      if (rems[k-1] < rdsc_pkg::REM_W'(10)) begin
        c.ch = rdsc_pkg::CHAR_ZERO + rdsc_pkg::CHAR_W'(rems[k-1]);
      end else begin
        c.ch = rdsc_pkg::CHAR_LOWER_A +
               rdsc_pkg::CHAR_W'(rems[k-1] - rdsc_pkg::REM_W'(10));
      end
      c.last = (k == 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    if (mismatches < REPORT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endfunction

  function automatic void queue_operand(input logic [rdsc_pkg::VALUE_W-1:0] value,
                                        input logic [rdsc_pkg::RADIX_W-1:0] radix,
                                        input bit drain_first);
    operand_t op;
    op.value       = value;
    op.radix       = radix;
    op.drain_first = drain_first;
    operand_backlog.push_back(op);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender. An item stays offered until it is taken; between items the sender
  // may idle, and an item marked drain_first waits for every character of the
  // earlier items to arrive before it is offered.
  always @(posedge clk) begin : drive_operands
    bit       offer;
    operand_t op;
    if (rst) begin
      operand_ch.valid <= 1'b0;
      operand_ch.value <= '0;
      operand_ch.radix <= '0;
    end else if (!operand_ch.valid || operand_ch.ready) begin
      offer = operand_backlog.size() != 0;
      if (offer && operand_backlog[0].drain_first) begin
        offer = !operand_ch.valid && pending_chars.size() == 0;
      end
      if (offer && !(operands_offered >= 120 && operands_offered < 180)) begin
        offer = $urandom_range(0, 99) >= 8;
      end
      if (offer) begin
        op = operand_backlog.pop_front();
        operand_ch.value <= op.value;
        operand_ch.radix <= op.radix;
        operands_offered <= operands_offered + 1;
      end
      operand_ch.valid <= offer;
    end
  end

  // Receiver. Stalls at random, not at all over a stretch of the run, and
  // once for a long hold-off so that the converter backs up into its input.
  always @(posedge clk) begin : drive_ready
    if (rst) begin
      digit_ch.ready <= 1'b0;
      hold_left      <= 0;
      hold_done      <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      digit_ch.ready <= 1'b0;
    end else if (!hold_done && chars_seen >= HOLD_AFTER) begin
      hold_left      <= HOLD_CYCLES;
      hold_done      <= 1'b1;
      digit_ch.ready <= 1'b0;
    end else if (chars_seen >= 1500 && chars_seen < 2200) begin
      digit_ch.ready <= 1'b1;
    end else begin
      digit_ch.ready <= $urandom_range(0, 99) >= 8;
    end
  end

  // Monitor. Characters are checked before a newly taken operand is spelled,
  // so an operand taken on the same edge as the final character of the
  // previous one lines up behind it.
  always @(posedge clk) begin : watch_channels
    char_t want;
    if (!rst) begin
      if (digit_ch.valid && digit_ch.ready) begin
        chars_seen <= chars_seen + 1;
        if (pending_chars.size() == 0) begin
          note_mismatch($sformatf("unexpected character 0x%0h last=%0b",
                                  digit_ch.digit_char, digit_ch.last));
        end else begin
          want = pending_chars.pop_front();
          if (digit_ch.digit_char !== want.ch) begin
            note_mismatch($sformatf("digit_char expected 0x%0h actual 0x%0h",
                                    want.ch, digit_ch.digit_char));
          end
          if (digit_ch.last !== want.last) begin
            note_mismatch($sformatf("last expected %0b actual %0b",
                                    want.last, digit_ch.last));
          end
        end
      end
      if (operand_ch.valid && operand_ch.ready) begin
        spell_value(operand_ch.value, operand_ch.radix);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin : watchdog
    if (rst || (operand_ch.valid && operand_ch.ready) ||
        (digit_ch.valid && digit_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [rdsc_pkg::VALUE_W-1:0] v;
    logic [rdsc_pkg::RADIX_W-1:0] r;
    int                           pick;
    mismatches       = 0;
    chars_seen       = 0;
    operands_offered = 0;
    quiet_cycles     = 0;
    hold_left        = 0;
    hold_done        = 1'b0;
    operand_ch.valid = 1'b0;
    operand_ch.value = '0;
    operand_ch.radix = '0;
    digit_ch.ready   = 1'b0;
    rst              = 1'b1;

    // Directed items: zero, field extremes, clamped radixes, every glyph.
    queue_operand('0, 5'd10, 1'b0);
    queue_operand('0, rdsc_pkg::RADIX_MIN, 1'b0);
    queue_operand(64'd1, rdsc_pkg::RADIX_MIN, 1'b0);
    queue_operand('1, rdsc_pkg::RADIX_MIN, 1'b0);
    queue_operand('1, rdsc_pkg::RADIX_MAX, 1'b0);
    queue_operand('1, 5'd3, 1'b0);
    queue_operand(64'h8000_0000_0000_0000, rdsc_pkg::RADIX_MIN, 1'b0);
    queue_operand(64'h0123_4567_89ab_cdef, rdsc_pkg::RADIX_MAX, 1'b0);
    queue_operand(64'hfedc_ba98_7654_3210, rdsc_pkg::RADIX_MAX, 1'b0);
    queue_operand(64'd1000, 5'd10, 1'b0);
    queue_operand(64'd15, rdsc_pkg::RADIX_MAX, 1'b0);
    queue_operand(64'd10, 5'd11, 1'b0);
    queue_operand(64'd35, 5'd7, 1'b0);
    // Radixes below two act as two; above sixteen act as sixteen.
    queue_operand(64'd5, 5'd0, 1'b0);
    queue_operand(64'd5, 5'd1, 1'b0);
    queue_operand(64'd255, 5'd17, 1'b0);
    queue_operand(64'd255, 5'd31, 1'b0);
    queue_operand('0, 5'd31, 1'b0);
    queue_operand(64'h5555_5555_5555_5555, 5'd4, 1'b0);
    queue_operand(64'haaaa_aaaa_aaaa_aaaa, 5'd8, 1'b0);
    queue_operand(64'd12345678901234567890, 5'd10, 1'b1);
    queue_operand(64'd99, 5'd9, 1'b0);
    queue_operand(64'h8000_0000_0000_0000, 5'd13, 1'b0);
    queue_operand(64'd14, 5'd15, 1'b0);
    queue_operand(64'h1_0000_0000, 5'd12, 1'b0);

    // Random items: mostly shortened values so conversions stay short on
    // average, with some zeros, full-width values and out-of-range radixes.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      v    = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        v = '0;
      end else if (pick >= 15) begin
        v = v >> $urandom_range(0, 63);
      end
      if ($urandom_range(0, 99) < 85) begin
        r = rdsc_pkg::RADIX_W'($urandom_range(2, 16));
      end else begin
        r = rdsc_pkg::RADIX_W'($urandom_range(0, 31));
      end
      queue_operand(v, r, i == 150 || i == 260);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (operand_backlog.size() != 0 || operand_ch.valid) begin
      @(negedge clk);
    end
    while (pending_chars.size() != 0) begin
      @(negedge clk);
    end
    repeat (30) @(negedge clk);

    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
